// File: sv/lcdnw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdnw_pkg
// Shared types, constants and tables of the character LCD nibble write
// sequencer: command codes, register indexes, controller states and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package lcdnw_pkg;

  // Field widths
  localparam int unsigned CmdW    = 2;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ColW    = 6;
  localparam int unsigned NibW    = 4;
  localparam int unsigned HoldW   = 10;
  localparam int unsigned PinW    = 6;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned IdxW    = 3;

  // Input commands
  localparam logic [CmdW-1:0] CMD_INSTR  = 2'd0;
  localparam logic [CmdW-1:0] CMD_DATA   = 2'd1;
  localparam logic [CmdW-1:0] CMD_CURSOR = 2'd2;
  localparam logic [CmdW-1:0] CMD_INIT   = 2'd3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_PULSE_HOLD    = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_POWER_UP_WAIT = 1'd1;

  // Configuration reset values
  localparam logic [HoldW-1:0] PULSE_HOLD_RST    = 10'd15;
  localparam logic [HoldW-1:0] POWER_UP_WAIT_RST = 10'd20;

  // Set-cursor instruction base
  localparam logic [ByteW-1:0] CURSOR_BASE = 8'h80;

  // Index of the final byte of the power-up sequence
  localparam logic [IdxW-1:0] INIT_LAST_IDX = 3'd5;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_PWR,
    S_EN_HI,
    S_EN_LO
  } state_e;

  // Pin-state operation requested from the datapath
  typedef enum logic [1:0] {
    OP_NONE,
    OP_PWR,
    OP_EN_HI,
    OP_EN_LO
  } op_e;

  // Controller to datapath
  typedef struct packed {
    logic            load;
    op_e             op;
    logic            nib_lo;
    logic            init_sel;
    logic [IdxW-1:0] idx;
    logic            last;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // Power-up instruction bytes
  function automatic logic [ByteW-1:0] init_byte(input logic [IdxW-1:0] idx);
    logic [ByteW-1:0] b;
    case (idx)
      3'd0:    b = 8'h02;
      3'd1:    b = 8'h28;
      3'd2:    b = 8'h0C;
      3'd3:    b = 8'h06;
      3'd4:    b = 8'h01;
      3'd5:    b = 8'h80;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: sv/lcdnw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdnw_ctrl
// Sequencing state machine: steps through the power-up wait, the enable
// high/low pair of each nibble and the bytes of the power-up sequence.
// ----------------------------------------------------------------------------
module lcdnw_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_is_init_i,
  output logic                   in_stall_o,
  input  lcdnw_pkg::dp_status_t  status_i,
  output lcdnw_pkg::ctrl_cmd_t   cmd_o
);

  lcdnw_pkg::state_e             state_q, state_d;
  logic                          nib_lo_q, nib_lo_d;
  logic                          init_q, init_d;
  logic [lcdnw_pkg::IdxW-1:0]    idx_q, idx_d;
  logic                          accept;
  logic                          final_lo;

  assign accept   = in_valid_i && (state_q == lcdnw_pkg::S_IDLE);
  assign final_lo = nib_lo_q && (!init_q || (idx_q == lcdnw_pkg::INIT_LAST_IDX));

  // Next state and step counters
  always_comb begin
    state_d  = state_q;
    nib_lo_d = nib_lo_q;
    init_d   = init_q;
    idx_d    = idx_q;
    case (state_q)
      lcdnw_pkg::S_IDLE: begin
        if (accept) begin
          nib_lo_d = 1'b0;
          idx_d    = '0;
          init_d   = in_is_init_i;
          state_d  = in_is_init_i ? lcdnw_pkg::S_PWR : lcdnw_pkg::S_EN_HI;
        end
      end
      lcdnw_pkg::S_PWR: begin
        if (status_i.out_free) begin
          state_d = lcdnw_pkg::S_EN_HI;
        end
      end
      lcdnw_pkg::S_EN_HI: begin
        if (status_i.out_free) begin
          state_d = lcdnw_pkg::S_EN_LO;
        end
      end
      lcdnw_pkg::S_EN_LO: begin
        if (status_i.out_free) begin
          if (final_lo) begin
            state_d = lcdnw_pkg::S_IDLE;
          end else begin
            state_d  = lcdnw_pkg::S_EN_HI;
            nib_lo_d = !nib_lo_q;
            if (nib_lo_q) begin
              idx_d = idx_q + 1'b1;
            end
          end
        end
      end
      default: state_d = lcdnw_pkg::S_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o          = '0;
    cmd_o.op       = lcdnw_pkg::OP_NONE;
    cmd_o.load     = accept;
    cmd_o.nib_lo   = nib_lo_q;
    cmd_o.init_sel = init_q;
    cmd_o.idx      = idx_q;
    in_stall_o     = (state_q != lcdnw_pkg::S_IDLE);
    case (state_q)
      lcdnw_pkg::S_PWR: begin
        if (status_i.out_free) cmd_o.op = lcdnw_pkg::OP_PWR;
      end
      lcdnw_pkg::S_EN_HI: begin
        if (status_i.out_free) cmd_o.op = lcdnw_pkg::OP_EN_HI;
      end
      lcdnw_pkg::S_EN_LO: begin
        if (status_i.out_free) begin
          cmd_o.op   = lcdnw_pkg::OP_EN_LO;
          cmd_o.last = final_lo;
        end
      end
      default: cmd_o.op = lcdnw_pkg::OP_NONE;
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lcdnw_pkg::S_IDLE;
      nib_lo_q <= 1'b0;
      init_q   <= 1'b0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      nib_lo_q <= nib_lo_d;
      init_q   <= init_d;
      idx_q    <= idx_d;
    end
  end

endmodule

// File: sv/lcdnw_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdnw_datapath
// Configuration registers, latched byte and RS level, pin-level state and
// the output register that holds one pin-state transaction.
// ----------------------------------------------------------------------------
module lcdnw_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lcdnw_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lcdnw_pkg::HoldW-1:0]   cfg_data_i,
  input  logic [lcdnw_pkg::CmdW-1:0]    command_i,
  input  logic [lcdnw_pkg::ByteW-1:0]   byte_value_i,
  input  logic                          row_i,
  input  logic [lcdnw_pkg::ColW-1:0]    col_i,
  input  lcdnw_pkg::ctrl_cmd_t          cmd_i,
  output lcdnw_pkg::dp_status_t         status_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          rs_o,
  output logic                          enable_o,
  output logic [lcdnw_pkg::NibW-1:0]    data_nibble_o,
  output logic [lcdnw_pkg::HoldW-1:0]   hold_ms_o,
  output logic                          last_o
);

  logic [lcdnw_pkg::HoldW-1:0] pulse_hold_q, power_wait_q;
  logic [lcdnw_pkg::ByteW-1:0] byte_q, byte_d;
  logic                        rs_q, rs_d;
  logic [lcdnw_pkg::PinW-1:0]  pin_q, pin_d;
  logic                        out_valid_q, out_valid_d;
  logic [lcdnw_pkg::PinW-1:0]  out_pin_q;
  logic [lcdnw_pkg::HoldW-1:0] out_hold_q, hold_d;
  logic                        out_last_q;
  logic [lcdnw_pkg::ByteW-1:0] cur_byte;
  logic [lcdnw_pkg::NibW-1:0]  cur_nib;
  logic                        emit;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_hold_q <= lcdnw_pkg::PULSE_HOLD_RST;
      power_wait_q <= lcdnw_pkg::POWER_UP_WAIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lcdnw_pkg::REG_PULSE_HOLD:    pulse_hold_q <= cfg_data_i;
        lcdnw_pkg::REG_POWER_UP_WAIT: power_wait_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Latch the byte and RS level of an accepted transaction
  always_comb begin
    byte_d = byte_q;
    rs_d   = rs_q;
    if (cmd_i.load) begin
      case (command_i)
        lcdnw_pkg::CMD_INSTR: begin
          byte_d = byte_value_i;
          rs_d   = 1'b0;
        end
        lcdnw_pkg::CMD_DATA: begin
          byte_d = byte_value_i;
          rs_d   = 1'b1;
        end
        lcdnw_pkg::CMD_CURSOR: begin
          byte_d = lcdnw_pkg::CURSOR_BASE | {1'b0, row_i, col_i};
          rs_d   = 1'b0;
        end
        default: begin
          byte_d = byte_q;
          rs_d   = 1'b0;
        end
      endcase
    end
  end

  // Select the byte and nibble being sent
  assign cur_byte = cmd_i.init_sel ? lcdnw_pkg::init_byte(cmd_i.idx) : byte_q;
  assign cur_nib  = cmd_i.nib_lo ? cur_byte[3:0] : cur_byte[7:4];

  // Build the next pin state and its hold time
  always_comb begin
    pin_d  = pin_q;
    hold_d = '0;
    case (cmd_i.op)
      lcdnw_pkg::OP_PWR: begin
        hold_d = power_wait_q;
      end
      lcdnw_pkg::OP_EN_HI: begin
        pin_d  = {cur_nib, 1'b1, rs_q};
        hold_d = pulse_hold_q;
      end
      lcdnw_pkg::OP_EN_LO: begin
        pin_d  = {pin_q[5:2], 1'b0, pin_q[0]};
        hold_d = '0;
      end
      default: begin
        pin_d  = pin_q;
        hold_d = '0;
      end
    endcase
  end

  assign emit              = (cmd_i.op != lcdnw_pkg::OP_NONE);
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  // Hold the output transaction until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control and pin state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pin_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      pin_q       <= pin_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    rs_q   <= rs_d;
    if (emit) begin
      out_pin_q  <= pin_d;
      out_hold_q <= hold_d;
      out_last_q <= cmd_i.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign rs_o          = out_pin_q[0];
  assign enable_o      = out_pin_q[1];
  assign data_nibble_o = out_pin_q[5:2];
  assign hold_ms_o     = out_hold_q;
  assign last_o        = out_last_q;

endmodule

// File: sv/char_lcd_nibble_write_sequencer.sv
`timescale 1ns / 1ps
// An accepted item's first pin-state transaction passes the controller state register, then
// the output register. Throughput: one pin-state transaction per cycle from the sequencing
// state machine while the output is free; a byte item gives 4 results, an initialize item 25.
// Downstream stall stretches each step; the next item is taken once the last result is issued.
// Reset: asynchronous, active low; pins clear to zero, pulse hold 15 ms, power-up wait 20 ms.
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// Character LCD 4-bit bus write sequencer: turns instruction, data, cursor
// and initialize commands into timed pin-state transactions.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lcdnw_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lcdnw_pkg::HoldW-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lcdnw_pkg::CmdW-1:0]    command_i,
  input  logic [lcdnw_pkg::ByteW-1:0]   byte_value_i,
  input  logic                          row_i,
  input  logic [lcdnw_pkg::ColW-1:0]    col_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          rs_o,
  output logic                          enable_o,
  output logic [lcdnw_pkg::NibW-1:0]    data_nibble_o,
  output logic [lcdnw_pkg::HoldW-1:0]   hold_ms_o,
  output logic                          last_o
);

  lcdnw_pkg::ctrl_cmd_t  cmd;
  lcdnw_pkg::dp_status_t status;

  // Sequencing controller
  lcdnw_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_is_init_i (command_i == lcdnw_pkg::CMD_INIT),
    .in_stall_o   (in_stall_o),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  // Pin-state datapath
  lcdnw_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .command_i     (command_i),
    .byte_value_i  (byte_value_i),
    .row_i         (row_i),
    .col_i         (col_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .rs_o          (rs_o),
    .enable_o      (enable_o),
    .data_nibble_o (data_nibble_o),
    .hold_ms_o     (hold_ms_o),
    .last_o        (last_o)
  );

endmodule

// File: tb/tb_char_lcd_nibble_write_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_write_sequencer
// Self-checking bench for the 4-bit character LCD write sequencer. A stimulus
// table covers the corner cases first. Random commands follow under several
// pulse-hold and power-up-wait settings. Every pin-state transaction is
// compared field by field with an in-bench model of the sequence. Both
// handshakes idle in random bursts, and one long output hold-off backs the
// block up into its input.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_write_sequencer;

  localparam int NUM_DIRECTED    = 17;
  localparam int NUM_PHASES      = 7;
  localparam int ITEMS_PER_PHASE = 63;
  localparam int SETTLE_CYCLES   = 6;
  localparam int LONG_HOLD       = 200;
  localparam int IDLE_LIMIT      = 2000;

  localparam logic [lcdnw_pkg::HoldW-1:0] PULSE_RST = lcdnw_pkg::PULSE_HOLD_RST;
  localparam logic [lcdnw_pkg::HoldW-1:0] WAIT_RST  = lcdnw_pkg::POWER_UP_WAIT_RST;

  localparam logic [lcdnw_pkg::ByteW-1:0] POWER_UP_BYTES [6] =
    '{8'h02, 8'h28, 8'h0C, 8'h06, 8'h01, 8'h80};

  typedef struct packed {
    logic                        rs;
    logic                        enable;
    logic [lcdnw_pkg::NibW-1:0]  nibble;
    logic [lcdnw_pkg::HoldW-1:0] hold;
    logic                        last;
  } pin_state_t;

  typedef struct packed {
    logic [lcdnw_pkg::CmdW-1:0]  cmd;
    logic [lcdnw_pkg::ByteW-1:0] byte_v;
    logic                        row;
    logic [lcdnw_pkg::ColW-1:0]  col;
    logic                        typed;
    pin_state_t                  first;
  } dir_row_t;

  logic                          clk_i;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_we_i      = 1'b0;
  logic [lcdnw_pkg::CfgIdxW-1:0] cfg_index_i   = '0;
  logic [lcdnw_pkg::HoldW-1:0]   cfg_data_i    = '0;
  logic                          in_valid_i    = 1'b0;
  logic                          in_stall_o;
  logic [lcdnw_pkg::CmdW-1:0]    command_i     = lcdnw_pkg::CMD_INSTR;
  logic [lcdnw_pkg::ByteW-1:0]   byte_value_i  = '0;
  logic                          row_i         = 1'b0;
  logic [lcdnw_pkg::ColW-1:0]    col_i         = '0;
  logic                          out_valid_o;
  logic                          out_stall_i   = 1'b0;
  logic                          rs_o;
  logic                          enable_o;
  logic [lcdnw_pkg::NibW-1:0]    data_nibble_o;
  logic [lcdnw_pkg::HoldW-1:0]   hold_ms_o;
  logic                          last_o;

  // Model state: pin levels (bit 0 RS, bit 1 E, bits 5:2 D7..D4) and registers
  logic [lcdnw_pkg::PinW-1:0]  model_pins       = '0;
  logic [lcdnw_pkg::HoldW-1:0] model_pulse_hold = PULSE_RST;
  logic [lcdnw_pkg::HoldW-1:0] model_wait       = WAIT_RST;

  pin_state_t pin_state_q[$];

  int  fail_count      = 0;
  int  results_checked = 0;
  int  items_sent      = 0;
  int  init_items      = 0;
  int  settings_used   = 1;
  int  idle_cycles     = 0;
  bit  calm            = 1'b0;
  bit  long_hold_done  = 1'b0;

  // Corner cases at reset settings; first pin state typed where obvious
  dir_row_t directed_rows [NUM_DIRECTED] = '{
    // power-up wait straight after reset repeats all-zero pins
    '{lcdnw_pkg::CMD_INIT,   8'h00, 1'b0, 6'd0,  1'b1, '{1'b0, 1'b0, 4'h0, WAIT_RST, 1'b0}},
    '{lcdnw_pkg::CMD_INSTR,  8'h00, 1'b0, 6'd0,  1'b1, '{1'b0, 1'b1, 4'h0, PULSE_RST, 1'b0}},
    '{lcdnw_pkg::CMD_INSTR,  8'hFF, 1'b0, 6'd0,  1'b1, '{1'b0, 1'b1, 4'hF, PULSE_RST, 1'b0}},
    '{lcdnw_pkg::CMD_DATA,   8'h00, 1'b0, 6'd0,  1'b1, '{1'b1, 1'b1, 4'h0, PULSE_RST, 1'b0}},
    '{lcdnw_pkg::CMD_DATA,   8'hFF, 1'b0, 6'd0,  1'b1, '{1'b1, 1'b1, 4'hF, PULSE_RST, 1'b0}},
    // row and col must be ignored on byte writes
    '{lcdnw_pkg::CMD_DATA,   8'hA5, 1'b1, 6'd63, 1'b0, '0},
    '{lcdnw_pkg::CMD_INSTR,  8'h5A, 1'b1, 6'h2A, 1'b0, '0},
    // cursor corners; byte_value must be ignored
    '{lcdnw_pkg::CMD_CURSOR, 8'hFF, 1'b0, 6'd0,  1'b1, '{1'b0, 1'b1, 4'h8, PULSE_RST, 1'b0}},
    '{lcdnw_pkg::CMD_CURSOR, 8'h00, 1'b1, 6'd63, 1'b1, '{1'b0, 1'b1, 4'hF, PULSE_RST, 1'b0}},
    '{lcdnw_pkg::CMD_CURSOR, 8'h00, 1'b1, 6'd0,  1'b1, '{1'b0, 1'b1, 4'hC, PULSE_RST, 1'b0}},
    '{lcdnw_pkg::CMD_CURSOR, 8'hFF, 1'b0, 6'd63, 1'b1, '{1'b0, 1'b1, 4'hB, PULSE_RST, 1'b0}},
    '{lcdnw_pkg::CMD_CURSOR, 8'h3C, 1'b1, 6'h2A, 1'b0, '0},
    // power-up wait after activity repeats the last driven pins
    '{lcdnw_pkg::CMD_INIT,   8'hFF, 1'b1, 6'd63, 1'b0, '0},
    '{lcdnw_pkg::CMD_DATA,   8'h0F, 1'b0, 6'd0,  1'b0, '0},
    '{lcdnw_pkg::CMD_DATA,   8'hF0, 1'b1, 6'd21, 1'b0, '0},
    '{lcdnw_pkg::CMD_INIT,   8'h55, 1'b0, 6'd21, 1'b0, '0},
    '{lcdnw_pkg::CMD_INSTR,  8'h01, 1'b0, 6'd0,  1'b0, '0}
  };

  char_lcd_nibble_write_sequencer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .byte_value_i (byte_value_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .rs_o         (rs_o),
    .enable_o     (enable_o),
    .data_nibble_o(data_nibble_o),
    .hold_ms_o    (hold_ms_o),
    .last_o       (last_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Record the current pins as one expected pin state
  function automatic void push_pins(logic [lcdnw_pkg::HoldW-1:0] hold);
    pin_state_t st;
    st.rs     = model_pins[0];
    st.enable = model_pins[1];
    st.nibble = model_pins[5:2];
    st.hold   = hold;
    st.last   = 1'b0;
    pin_state_q.push_back(st);
  endfunction

  // One nibble: enable high for the pulse time, then enable low
  function automatic void push_nibble(logic rs, logic [lcdnw_pkg::NibW-1:0] nib);
    model_pins = {nib, 1'b1, rs};
    push_pins(model_pulse_hold);
    model_pins[1] = 1'b0;
    push_pins('0);
  endfunction

  function automatic void push_byte(logic rs, logic [lcdnw_pkg::ByteW-1:0] b);
    push_nibble(rs, b[7:4]);
    push_nibble(rs, b[3:0]);
  endfunction

  // Expand one command into its pin-state sequence
  function automatic void predict_pin_states(logic [lcdnw_pkg::CmdW-1:0] cmd,
                                             logic [lcdnw_pkg::ByteW-1:0] b,
                                             logic row, logic [lcdnw_pkg::ColW-1:0] col);
    pin_state_t tail;
    case (cmd)
      lcdnw_pkg::CMD_INSTR:  push_byte(1'b0, b);
      lcdnw_pkg::CMD_DATA:   push_byte(1'b1, b);
      lcdnw_pkg::CMD_CURSOR: push_byte(1'b0, lcdnw_pkg::CURSOR_BASE | {1'b0, row, col});
      default: begin
        push_pins(model_wait);
        for (int i = 0; i < 6; i++) push_byte(1'b0, POWER_UP_BYTES[i]);
      end
    endcase
    tail = pin_state_q.pop_back();
    tail.last = 1'b1;
    pin_state_q.push_back(tail);
  endfunction

  function automatic void check_field(string name, int want_v, int got_v);
    if (want_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endfunction

  // Offer one command after an optional gap; predict once it is taken
  task automatic send_command(logic [lcdnw_pkg::CmdW-1:0] cmd,
                              logic [lcdnw_pkg::ByteW-1:0] b, logic row,
                              logic [lcdnw_pkg::ColW-1:0] col, logic typed,
                              pin_state_t first);
    int base;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    byte_value_i <= b;
    row_i        <= row;
    col_i        <= col;
    do @(posedge clk_i); while (in_stall_o);
    base = pin_state_q.size();
    predict_pin_states(cmd, b, row, col);
    if (typed) pin_state_q[base] = first;
    items_sent++;
    if (cmd == lcdnw_pkg::CMD_INIT) init_items++;
  endtask

  task automatic write_reg(logic [lcdnw_pkg::CfgIdxW-1:0] idx,
                           logic [lcdnw_pkg::HoldW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == lcdnw_pkg::REG_PULSE_HOLD) model_pulse_hold = value;
    else model_wait = value;
    @(posedge clk_i);
  endtask

  // Wait for every expected pin state, then let the controller settle
  task automatic wait_drained();
    while (pin_state_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Stimulus
  initial begin
    logic [lcdnw_pkg::HoldW-1:0] pulse_v;
    logic [lcdnw_pkg::HoldW-1:0] wait_v;
    logic [lcdnw_pkg::CmdW-1:0]  cmd;
    logic [lcdnw_pkg::ByteW-1:0] b;
    logic                        row_v;
    logic [lcdnw_pkg::ColW-1:0]  col_v;
    int                          rnd;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_command(directed_rows[i].cmd, directed_rows[i].byte_v, directed_rows[i].row,
                   directed_rows[i].col, directed_rows[i].typed, directed_rows[i].first);
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        wait_drained();
        calm = (phase == NUM_PHASES - 1);
        case (phase)
          1:       begin pulse_v = '0;  wait_v = '0;  end
          2:       begin pulse_v = '1;  wait_v = '1;  end
          4:       begin pulse_v = '1;  wait_v = '0;  end
          5:       begin pulse_v = '0;  wait_v = '1;  end
          default: begin
            rnd     = $urandom_range(0, 1023);
            pulse_v = rnd[lcdnw_pkg::HoldW-1:0];
            rnd     = $urandom_range(0, 1023);
            wait_v  = rnd[lcdnw_pkg::HoldW-1:0];
          end
        endcase
        write_reg(lcdnw_pkg::REG_PULSE_HOLD, pulse_v);
        write_reg(lcdnw_pkg::REG_POWER_UP_WAIT, wait_v);
        settings_used++;
      end
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // initialize is long, so keep it rare
        if ($urandom_range(0, 9) == 0) begin
          cmd = lcdnw_pkg::CMD_INIT;
        end else begin
          rnd = $urandom_range(0, 2);
          cmd = rnd[lcdnw_pkg::CmdW-1:0];
        end
        case ($urandom_range(0, 7))
          0:       b = '0;
          1:       b = '1;
          default: begin
            rnd = $urandom_range(0, 255);
            b   = rnd[lcdnw_pkg::ByteW-1:0];
          end
        endcase
        rnd   = $urandom_range(0, 1);
        row_v = rnd[0];
        rnd   = $urandom_range(0, 63);
        col_v = rnd[lcdnw_pkg::ColW-1:0];
        send_command(cmd, b, row_v, col_v, 1'b0, '0);
      end
      in_valid_i <= 1'b0;
    end

    wait_drained();
    $display("Sent %0d commands (%0d initialize) over %0d register settings.",
             items_sent, init_items, settings_used);
    $display("Checked %0d pin states with random idling and one long output hold-off.",
             results_checked);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Output stall: random bursts, plus one long hold-off to back up the input
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!calm && !long_hold_done && results_checked >= 100) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
        long_hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare each pin-state transaction with the oldest expectation
  always @(posedge clk_i) begin : check_pins
    pin_state_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pin_state_q.size() == 0) begin
        $error("unexpected pin state: rs %0d e %0d d %0h hold %0d last %0d",
               rs_o, enable_o, data_nibble_o, hold_ms_o, last_o);
        fail_count++;
      end else begin
        want = pin_state_q.pop_front();
        check_field("rs", int'(want.rs), int'(rs_o));
        check_field("enable", int'(want.enable), int'(enable_o));
        check_field("data_nibble", int'(want.nibble), int'(data_nibble_o));
        check_field("hold_ms", int'(want.hold), int'(hold_ms_o));
        check_field("last", int'(want.last), int'(last_o));
      end
      results_checked++;
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
